// ----- hdl/qrv_pkg.sv -----
package qrv_pkg;

    localparam int FRAC_BITS_DEF = 14;

    localparam int VEC_W  = 16;           // quaternion and vector fields
    localparam int OUT_W  = 32;           // result fields
    localparam int ROOT_W = 32;           // root of the 64-bit radicand S * 2^32

    // first product, rounded back to FRAC_BITS fraction bits
    localparam int P_W    = 20;
    // conjugate component, one bit wider so that the negated minimum fits
    localparam int C_W    = VEC_W + 1;
    localparam int PR2_W  = P_W + C_W;
    localparam int SUM2_W = PR2_W + 2;

    // per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic [3:0][VEC_W-1:0] quat;      // x, y, z, w
        logic [2:0][VEC_W-1:0] mag;       // |vec| per component
        logic [2:0]            neg;       // vec component sign
        logic                  zero;      // vector was all zero
    } side_t;

endpackage

// ----- hdl/qrv_if.sv -----
interface qrv_in_if import qrv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] quat_x;
    logic signed [VEC_W-1:0] quat_y;
    logic signed [VEC_W-1:0] quat_z;
    logic signed [VEC_W-1:0] quat_w;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

interface qrv_out_if import qrv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic signed [OUT_W-1:0] out_w;
    logic                    zero_vector;

    modport source (
        output valid, out_x, out_y, out_z, out_w, zero_vector,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, zero_vector,
        output ready
    );
endinterface

// ----- hdl/qrv_sqrt_pipe.sv -----
module qrv_sqrt_pipe import qrv_pkg::*; (
    input  logic              clk,
    input  logic [ROOT_W-1:0] en,
    input  logic [ROOT_W-1:0] rad,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int HALF  = ROOT_W / 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] rad_reg  [ROOT_W];

    // one result bit per stage, radicand bit pairs from the top down
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int PAIR = ROOT_W - 1 - k;

        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_nx;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_nx;
        logic [ROOT_W-1:0] rad_in;
        logic [1:0]        bits;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // low half of the radicand is zero
        if (PAIR >= HALF) begin : g_rad
            assign bits = rad_in[2*(PAIR-HALF)+1 -: 2];
        end else begin : g_pad
            assign bits = 2'b00;
        end

        assign rem_sh = {rem_in[REM_W-3:0], bits};
        assign trial  = REM_W'({root_in, 2'b01});

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_nx  = rem_sh - trial;
                root_nx = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_nx  = rem_sh;
                root_nx = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_nx;
                root_reg[k] <= root_nx;
                rad_reg[k]  <= rad_in;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ----- hdl/qrv_div_pipe.sv -----
module qrv_div_pipe import qrv_pkg::*; #(
    parameter  int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QUOT_W    = FRAC_BITS + 2,
    localparam int NUM_W     = FRAC_BITS + 32
) (
    input  logic                        clk,
    input  logic [QUOT_W-1:0]           en,
    input  logic [2:0][NUM_W-1:0]       num,
    input  logic [ROOT_W-1:0]           den,
    output logic [2:0][QUOT_W-1:0]      quot
);

    logic [2:0][NUM_W-1:0]  rem_reg  [QUOT_W];
    logic [2:0][QUOT_W-1:0] quot_reg [QUOT_W];
    logic [ROOT_W-1:0]      den_reg  [QUOT_W];

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        localparam int QB = QUOT_W - 1 - k;

        logic [2:0][NUM_W-1:0]  rem_in;
        logic [2:0][NUM_W-1:0]  rem_nx;
        logic [2:0][QUOT_W-1:0] q_in;
        logic [2:0][QUOT_W-1:0] q_nx;
        logic [ROOT_W-1:0]      d_in;
        logic [NUM_W:0]         d_sh;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign d_in   = den;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = quot_reg[k-1];
            assign d_in   = den_reg[k-1];
        end

        assign d_sh = (NUM_W + 1)'(d_in) << QB;

        always_comb
        begin
            rem_nx = rem_in;
            q_nx   = q_in;
            for (int l = 0; l < 3; l++)
            begin
                if ({1'b0, rem_in[l]} >= d_sh)
                begin
                    rem_nx[l]     = rem_in[l] - d_sh[NUM_W-1:0];
                    q_nx[l][QB]   = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_nx;
                quot_reg[k] <= q_nx;
                den_reg[k]  <= d_in;
            end
        end
    end

    assign quot = quot_reg[QUOT_W-1];

endmodule

// ----- hdl/quat_rotate_vector.sv -----
// Quaternion rotation of a 3-vector, fully pipelined.
//
// sample: one item carries quaternion q (Q1.14 style, FRAC_BITS fraction bits)
//   and an integer vector v of any scale. result: one item per sample with
//   r = q*(1 + unit(v))*conj(q); out_x/y/z is the rotated unit vector scaled by
//   |q|^2, out_w is |q|^2, all with FRAC_BITS fraction bits and saturated to
//   32 bits. A zero vector gives zero results with zero_vector set.
//
// Throughput: one item per cycle while the receiver takes results. The pipeline
//   holds the 32-stage square root (one root bit per stage) and the FRAC_BITS + 2
//   stage divider (one quotient bit per stage, three lanes).
//   The remaining stages are squares, sum, numerators, clamp, two product
//   stages and two sum/round stages, with a register after every multiply.
//
// Reset clears every stage valid bit; payload registers are not reset.
// Each stage holds its item only while the stage ahead is full and stalled,
//   so a stalled receiver backs the pipeline up one stage at a time; empty
//   stages keep filling, and sample.ready drops only once all are full.
module quat_rotate_vector import qrv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    qrv_in_if.sink   sample,
    qrv_out_if.source result
);

    localparam int QUOT_W = FRAC_BITS + 2;
    localparam int N_W    = FRAC_BITS + 2;
    localparam int NUM_W  = FRAC_BITS + 32;
    localparam int PR1_W  = FRAC_BITS + 18;
    localparam int SUM1_W = FRAC_BITS + 21;

    // stage map
    localparam int ST_SQ   = 0;
    localparam int ST_SUM  = ST_SQ + 1;
    localparam int ST_RT0  = ST_SUM + 1;
    localparam int ST_NUM  = ST_RT0 + ROOT_W;
    localparam int ST_DV0  = ST_NUM + 1;
    localparam int ST_UNIT = ST_DV0 + QUOT_W;
    localparam int ST_P1   = ST_UNIT + 1;
    localparam int ST_P    = ST_P1 + 1;
    localparam int ST_P2   = ST_P + 1;
    localparam int ST_OUT  = ST_P2 + 1;
    localparam int NS      = ST_OUT + 1;

    localparam logic [QUOT_W-1:0]        UNIT_ONE = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic signed [SUM1_W-1:0] HALF1    = SUM1_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM2_W-1:0] HALF2    = SUM2_W'(1) << (FRAC_BITS - 1);

    // ---------------- stage control ----------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   adv;

    // a stage may load when it is empty or its contents move on
    assign adv[NS] = result.ready;
    for (genvar i = 0; i < NS; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign vld_next     = {vld_reg[NS-2:0], sample.valid};
    assign sample.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // ---------------- side data ----------------
    side_t                   side_in;
    side_t                   side_reg [NS];
    logic signed [VEC_W-1:0] vv [3];

    assign vv[0] = sample.vec_x;
    assign vv[1] = sample.vec_y;
    assign vv[2] = sample.vec_z;

    always_comb
    begin
        side_in.quat[0] = sample.quat_x;
        side_in.quat[1] = sample.quat_y;
        side_in.quat[2] = sample.quat_z;
        side_in.quat[3] = sample.quat_w;
        for (int l = 0; l < 3; l++)
        begin
            side_in.neg[l] = vv[l][VEC_W-1];
            side_in.mag[l] = vv[l][VEC_W-1] ? VEC_W'(-vv[l]) : vv[l];
        end
        side_in.zero = (vv[0] == '0) && (vv[1] == '0) && (vv[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- squares and sum ----------------
    logic signed [2*VEC_W-1:0] sq_full [3];
    logic [2*VEC_W-2:0]        sq_reg  [3];
    logic [ROOT_W-1:0]         s_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sq_full[l] = vv[l] * vv[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_SQ])
        begin
            for (int l = 0; l < 3; l++)
            begin
                sq_reg[l] <= sq_full[l][2*VEC_W-2:0];
            end
        end
        if (adv[ST_SUM])
        begin
            s_reg <= ROOT_W'(sq_reg[0]) + ROOT_W'(sq_reg[1]) + ROOT_W'(sq_reg[2]);
        end
    end

    // ---------------- norm: floor(sqrt(S * 2^32)) ----------------
    logic [ROOT_W-1:0] root;

    qrv_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (adv[ST_RT0 +: ROOT_W]),
        .rad  (s_reg),
        .root (root)
    );

    // ---------------- numerators and division ----------------
    logic [2:0][NUM_W-1:0]  num_reg;
    logic [ROOT_W-1:0]      den_reg;
    logic [2:0][QUOT_W-1:0] quot;

    always_ff @(posedge clk)
    begin
        if (adv[ST_NUM])
        begin
            for (int l = 0; l < 3; l++)
            begin
                // |v| * 2^(FRAC_BITS+16) plus half the divisor to round
                num_reg[l] <= (NUM_W'(side_reg[ST_NUM-1].mag[l]) << (FRAC_BITS + 16))
                              + NUM_W'(root >> 1);
            end
            den_reg <= root;
        end
    end

    qrv_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .en   (adv[ST_DV0 +: QUOT_W]),
        .num  (num_reg),
        .den  (den_reg),
        .quot (quot)
    );

    // ---------------- unit vector: clamp to one, restore sign ----------------
    logic [QUOT_W-1:0]     mq   [3];
    logic signed [N_W-1:0] n_reg [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mq[l] = (quot[l] > UNIT_ONE) ? UNIT_ONE : quot[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_UNIT])
        begin
            for (int l = 0; l < 3; l++)
            begin
                n_reg[l] <= side_reg[ST_UNIT-1].neg[l] ? -mq[l] : mq[l];
            end
        end
    end

    // ---------------- first product p = q * n ----------------
    // the scalar part of n is one, so those terms are shifts
    logic signed [PR1_W-1:0]  pr1_reg [4][3];
    logic signed [SUM1_W-1:0] pe      [4][3];
    logic signed [SUM1_W-1:0] qsh     [4];
    logic signed [SUM1_W-1:0] p_sum   [4];
    logic signed [P_W-1:0]    p_reg   [4];

    always_ff @(posedge clk)
    begin
        if (adv[ST_P1])
        begin
            for (int j = 0; j < 4; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pr1_reg[j][k] <= PR1_W'($signed(side_reg[ST_UNIT].quat[j]))
                                     * PR1_W'(n_reg[k]);
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            qsh[j] = SUM1_W'($signed(side_reg[ST_P1].quat[j])) <<< FRAC_BITS;
            for (int k = 0; k < 3; k++)
            begin
                pe[j][k] = SUM1_W'(pr1_reg[j][k]);
            end
        end
        p_sum[3] = qsh[3] - pe[0][0] - pe[1][1] - pe[2][2];
        p_sum[0] = pe[3][0] + qsh[0] + pe[1][2] - pe[2][1];
        p_sum[1] = pe[3][1] - pe[0][2] + qsh[1] + pe[2][0];
        p_sum[2] = pe[3][2] + pe[0][1] - pe[1][0] + qsh[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_P])
        begin
            for (int i = 0; i < 4; i++)
            begin
                p_reg[i] <= P_W'((p_sum[i] + HALF1) >>> FRAC_BITS);
            end
        end
    end

    // ---------------- second product r = p * conj(q) ----------------
    logic signed [C_W-1:0]    cq      [4];
    logic signed [PR2_W-1:0]  pr2_reg [4][4];
    logic signed [SUM2_W-1:0] re      [4][4];
    logic signed [SUM2_W-1:0] r_sum   [4];
    logic signed [SUM2_W-1:0] r_rnd   [4];
    logic signed [OUT_W-1:0]  r_sat   [4];
    logic signed [OUT_W-1:0]  out_reg [4];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            cq[j] = -C_W'($signed(side_reg[ST_P].quat[j]));
        end
        cq[3] = C_W'($signed(side_reg[ST_P].quat[3]));
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_P2])
        begin
            for (int m = 0; m < 4; m++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pr2_reg[m][j] <= PR2_W'(p_reg[m]) * PR2_W'(cq[j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                re[m][j] = SUM2_W'(pr2_reg[m][j]);
            end
        end
        r_sum[3] = re[3][3] - re[0][0] - re[1][1] - re[2][2];
        r_sum[0] = re[3][0] + re[0][3] + re[1][2] - re[2][1];
        r_sum[1] = re[3][1] - re[0][2] + re[1][3] + re[2][0];
        r_sum[2] = re[3][2] + re[0][1] - re[1][0] + re[2][3];
        for (int i = 0; i < 4; i++)
        begin
            r_rnd[i] = (r_sum[i] + HALF2) >>> FRAC_BITS;
            // saturate when the bits above the result are not all sign
            if ((&r_rnd[i][SUM2_W-1:OUT_W-1]) || !(|r_rnd[i][SUM2_W-1:OUT_W-1]))
            begin
                r_sat[i] = r_rnd[i][OUT_W-1:0];
            end
            else if (r_rnd[i][SUM2_W-1])
            begin
                r_sat[i] = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                r_sat[i] = {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            for (int i = 0; i < 4; i++)
            begin
                // drop the arithmetic result of a zero vector
                out_reg[i] <= side_reg[ST_P2].zero ? '0 : r_sat[i];
            end
        end
    end

    assign result.valid       = vld_reg[ST_OUT];
    assign result.out_x       = out_reg[0];
    assign result.out_y       = out_reg[1];
    assign result.out_z       = out_reg[2];
    assign result.out_w       = out_reg[3];
    assign result.zero_vector = side_reg[ST_OUT].zero;

endmodule

// ----- hdl/qrv_checker.sv -----
module qrv_checker import qrv_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] out_x,
    input logic [OUT_W-1:0] out_y,
    input logic [OUT_W-1:0] out_z,
    input logic [OUT_W-1:0] out_w,
    input logic             zero_vector
);

    // a zero vector never carries arithmetic results
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_vector) |->
            (out_x == '0) && (out_y == '0) && (out_z == '0) && (out_w == '0))
        else $error("zero vector with nonzero result");

    // with the output free, nothing can block the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled while output side is free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z)
            && $stable(out_w) && $stable(zero_vector))
        else $error("stalled result changed");

endmodule

bind quat_rotate_vector qrv_checker u_qrv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_x       (result.out_x),
    .out_y       (result.out_y),
    .out_z       (result.out_z),
    .out_w       (result.out_w),
    .zero_vector (result.zero_vector)
);

// ----- dv/quat_rotate_vector_tb.sv -----
module quat_rotate_vector_tb;
    import qrv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LATENCY   = FRAC + 42;
    localparam int STALL_MAX = 20000;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] w;
        logic                    zero;
    } rotation_t;

    logic clk;
    logic rst_n;

    qrv_in_if  sample ();
    qrv_out_if result ();

    quat_rotate_vector #(.FRAC_BITS(FRAC)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    // Expected rotations in arrival order.
    rotation_t expected_rot[$];

    int errors = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Integer square root, bit by bit.
    function automatic logic [63:0] root64(logic [63:0] a);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= res + b)
            begin
                a   = a - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Round to FRAC fraction bits: add half, then floor shift.
    function automatic longint round_q(longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Hamilton product, components x, y, z, w.
    function automatic void ham(input longint a[4], input longint b[4],
                                output longint r[4]);
        r[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
        r[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
        r[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
        r[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
    endfunction

    function automatic rotation_t rotate(input logic signed [VEC_W-1:0] q[4],
                                         input logic signed [VEC_W-1:0] v[3]);
        rotation_t   res;
        longint      qq[4], qc[4], n[4], p[4], r[4];
        longint      vv, mag, quo;
        logic [63:0] s, nrm;
        res = '{0, 0, 0, 0, 1'b0};
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            vv = longint'(v[i]);
            s  = s + 64'(vv * vv);
        end
        if (s == 0)
        begin
            res.zero = 1'b1;
            return res;
        end
        nrm = root64(s << 32);
        for (int i = 0; i < 3; i++)
        begin
            vv  = longint'(v[i]);
            mag = (vv < 0) ? -vv : vv;
            quo = longint'(((64'(mag) << (FRAC + 16)) + (nrm >> 1)) / nrm);
            if (quo > (longint'(1) << FRAC))
                quo = longint'(1) << FRAC;
            n[i] = (vv < 0) ? -quo : quo;
        end
        n[3] = longint'(1) << FRAC;
        for (int i = 0; i < 4; i++)
            qq[i] = longint'(q[i]);
        ham(qq, n, p);
        for (int i = 0; i < 4; i++)
            p[i] = round_q(p[i]);
        qc[0] = -qq[0];
        qc[1] = -qq[1];
        qc[2] = -qq[2];
        qc[3] = qq[3];
        ham(p, qc, r);
        res.x = OUT_W'(clip32(round_q(r[0])));
        res.y = OUT_W'(clip32(round_q(r[1])));
        res.z = OUT_W'(clip32(round_q(r[2])));
        res.w = OUT_W'(clip32(round_q(r[3])));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Drive one item, hold it until accepted, and queue its expected rotation.
    task automatic send_item(input logic signed [VEC_W-1:0] q[4],
                             input logic signed [VEC_W-1:0] v[3]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid  <= 1'b1;
        sample.quat_x <= q[0];
        sample.quat_y <= q[1];
        sample.quat_z <= q[2];
        sample.quat_w <= q[3];
        sample.vec_x  <= v[0];
        sample.vec_y  <= v[1];
        sample.vec_z  <= v[2];
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        expected_rot.push_back(rotate(q, v));
    endtask

    // Receiver: random stall, check each accepted item against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        rotation_t want;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_rot.size() == 0)
                begin
                    $display("unexpected result item at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_rot.pop_front();
                    if (result.out_x !== want.x)
                        report_mismatch("out_x", longint'(result.out_x), longint'(want.x));
                    if (result.out_y !== want.y)
                        report_mismatch("out_y", longint'(result.out_y), longint'(want.y));
                    if (result.out_z !== want.z)
                        report_mismatch("out_z", longint'(result.out_z), longint'(want.z));
                    if (result.out_w !== want.w)
                        report_mismatch("out_w", longint'(result.out_w), longint'(want.w));
                    if (result.zero_vector !== want.zero)
                        report_mismatch("zero_vector", longint'(result.zero_vector),
                                        longint'(want.zero));
                end
            end
            result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX)
        begin
            $display("quat_rotate_vector_tb NOT OK");
            $finish;
        end
    end

    function automatic logic signed [VEC_W-1:0] rand16();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(1 << FRAC);
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed corners: zero vector, extremes, identity, axis vectors, saturation.
    task automatic test_corners();
        logic signed [VEC_W-1:0] q[4];
        logic signed [VEC_W-1:0] v[3];
        q = '{0, 0, 0, 16'(1 << FRAC)};
        v = '{0, 0, 0};
        send_item(q, v);
        v = '{1, 0, 0};
        send_item(q, v);
        v = '{0, -1, 0};
        send_item(q, v);
        v = '{0, 0, 16'sh7fff};
        send_item(q, v);
        v = '{16'sh8000, 16'sh8000, 16'sh8000};
        send_item(q, v);
        v = '{16'sh8000, 0, 0};
        send_item(q, v);
        q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_item(q, v);
        v = '{16'sh7fff, 16'sh8000, 16'sh7fff};
        send_item(q, v);
        q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_item(q, v);
        v = '{0, 0, 0};
        send_item(q, v);
        q = '{16'sh7fff, 16'sh8000, 0, 16'sh7fff};
        v = '{3, 4, 0};
        send_item(q, v);
        q = '{16'sh2d41, 0, 0, 16'sh2d41};
        v = '{0, 1, 0};
        send_item(q, v);
        v = '{-1, -1, -1};
        send_item(q, v);
        q = '{-1, -1, -1, -1};
        v = '{16'sh5555, 16'shaaaa, 16'sh00ff};
        send_item(q, v);
    endtask

    // Random items; some zero vectors and some small vectors mixed in.
    task automatic test_random(input int count);
        logic signed [VEC_W-1:0] q[4];
        logic signed [VEC_W-1:0] v[3];
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < 4; i++)
                q[i] = rand16();
            for (int i = 0; i < 3; i++)
            begin
                case ($urandom_range(7))
                    0: v[i] = 0;
                    1: v[i] = 16'($urandom_range(7)) - 16'sd3;
                    default: v[i] = rand16();
                endcase
            end
            if ($urandom_range(31) == 0)
                v = '{0, 0, 0};
            send_item(q, v);
        end
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        while (expected_rot.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 27;
        recv_idle_pct = 54;
        rst_n         = 1'b0;
        sample.valid  = 1'b0;
        sample.quat_x = '0;
        sample.quat_y = '0;
        sample.quat_z = '0;
        sample.quat_w = '0;
        sample.vec_x  = '0;
        sample.vec_y  = '0;
        sample.vec_z  = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_random(190);
        // Swap idle rates, then run back to back.
        send_idle_pct = 54;
        recv_idle_pct = 27;
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);
        drain();

        if (errors == 0)
            $display("quat_rotate_vector_tb OK");
        else
            $display("quat_rotate_vector_tb NOT OK");
        $finish;
    end

endmodule
